[hdl/cdq_pkg.sv]
// Shared constants, codes and inter-module types for the circular deque.
package cdq_pkg;

  localparam int DEPTH      = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  // index compare width: wide enough for both the 4-bit position and the count
  localparam int IDX_W      = (CNT_W > 4) ? CNT_W : 4;
  localparam int SUM_W      = IDX_W + 1;

  localparam int IN_TDATA_W   = 40;  // position(4) + item_value(32), byte padded
  localparam int IN_TUSER_W   = 3;   // operation
  localparam int OUT_TDATA_W  = 40;  // result_value(32) + count_now(5), byte padded
  localparam int OUT_TUSER_W  = 2;   // status

  typedef enum logic [2:0] {
    OP_GET   = 3'd0,
    OP_PUT   = 3'd1,
    OP_ADDHI = 3'd2,
    OP_ADDLO = 3'd3,
    OP_REMHI = 3'd4,
    OP_REMLO = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // one access to the ring memory per word
  typedef struct packed {
    logic                  we;
    logic [PTR_W-1:0]      addr;
    logic [ELEM_WIDTH-1:0] wdata;
  } mem_cmd_t;

  // what the output stage needs to build the result word
  typedef struct packed {
    logic                  from_mem;
    logic [ELEM_WIDTH-1:0] imm;
    status_t               status;
    logic [CNT_W-1:0]      count;
  } res_info_t;

endpackage

[hdl/cdq_ram.sv]
// Single-port ring memory, read-before-write, registered read data.
module cdq_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [WIDTH_P-1:0] wdata,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/cdq_ctrl.sv]
// Head/count registers, operation decode and ring slot computation.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  op_t                   op,
  input  logic [3:0]            position,
  input  logic [ELEM_WIDTH-1:0] elem_in,
  output mem_cmd_t              cmd,
  output res_info_t             info
);

  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [SUM_W-1:0] pos_s, cnt_s, cnt_m1_s, sum_pos, sum_cnt, sum_m1;
  logic [PTR_W-1:0] slot_pos, slot_cnt, slot_m1, head_dec, head_inc;
  logic             is_full, is_empty, out_range;

  always_comb begin
    pos_s    = SUM_W'(position);
    cnt_s    = SUM_W'(count_r);
    cnt_m1_s = cnt_s - SUM_W'(1);
    sum_pos  = SUM_W'(head_r) + pos_s;
    sum_cnt  = SUM_W'(head_r) + cnt_s;
    sum_m1   = SUM_W'(head_r) + cnt_m1_s;
    // sums in use stay below twice the depth: one compare and subtract wraps them
    slot_pos = PTR_W'((sum_pos >= DEPTH_S) ? sum_pos - DEPTH_S : sum_pos);
    slot_cnt = PTR_W'((sum_cnt >= DEPTH_S) ? sum_cnt - DEPTH_S : sum_cnt);
    slot_m1  = PTR_W'((sum_m1  >= DEPTH_S) ? sum_m1  - DEPTH_S : sum_m1);
    head_dec = (head_r == '0) ? LAST_SLOT : head_r - PTR_W'(1);
    head_inc = (head_r == LAST_SLOT) ? '0 : head_r + PTR_W'(1);
    is_full   = (cnt_s >= DEPTH_S);
    is_empty  = (count_r == '0);
    out_range = (pos_s >= cnt_s);
  end

  always_comb begin
    cmd.we        = 1'b0;
    cmd.addr      = head_r;
    cmd.wdata     = elem_in;
    info.from_mem = 1'b0;
    info.imm      = '0;
    info.status   = ST_OK;
    head_nxt      = head_r;
    count_nxt     = count_r;
    case (op)
      OP_GET, OP_PUT: begin
        if (out_range) begin
          info.status = ST_RANGE;
        end else begin
          cmd.addr      = slot_pos;
          cmd.we        = (op == OP_PUT);
          info.from_mem = 1'b1;
        end
      end
      OP_ADDHI: begin
        if (is_full) begin
          info.status = ST_FULL;
        end else begin
          cmd.addr  = slot_cnt;
          cmd.we    = 1'b1;
          info.imm  = elem_in;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_ADDLO: begin
        if (is_full) begin
          info.status = ST_FULL;
        end else begin
          cmd.addr  = head_dec;
          cmd.we    = 1'b1;
          info.imm  = elem_in;
          head_nxt  = head_dec;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMHI: begin
        if (is_empty) begin
          info.status = ST_EMPTY;
        end else begin
          cmd.addr      = slot_m1;
          info.from_mem = 1'b1;
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      OP_REMLO: begin
        if (is_empty) begin
          info.status = ST_EMPTY;
        end else begin
          cmd.addr      = head_r;
          info.from_mem = 1'b1;
          head_nxt      = head_inc;
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    info.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[hdl/circular_deque.sv]
// Top level of the circular deque: ring memory, control and output stage.
//
// Usage: a double-ended queue of DEPTH elements held in a single-port ring
// memory. Each input word carries one operation on in_tuser (get, put, add
// high, add low, remove high, remove low) with the position and element
// value on in_tdata. Every accepted word produces exactly one result word:
// the element read, replaced, added or removed (zero on error) and the count
// after the operation on out_tdata, and the status on out_tuser.
// Pipeline: read data and the read-stage word are registered at the accept
// edge, then the output register loads them once it is free or draining,
// and out_tvalid rises with that load. Throughput: 1 word per cycle while
// out_tready does not stall the output; head and count update at accept,
// and each word makes one read-before-write memory access, so back-to-back
// words on the same slot need no forwarding.
// Stall: when out_tready is low the output register holds its word and one
// more word may sit in the memory-read stage; in_tready drops only when both
// are full, so no word is lost.
// Reset: rst_n (synchronous, active low) empties the deque (head and count
// to zero) and drops both stage valids. Memory contents are not cleared;
// only written slots are ever read back.
module circular_deque
  import cdq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [3:0] position, [35:4] item_value, pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [2:0] operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] result_value, [36:32] count_now, pad
  output logic [OUT_TUSER_W-1:0] out_tuser   // [1:0] status
);

  logic                  accept;
  mem_cmd_t              cmd;
  res_info_t             info;
  logic [ELEM_WIDTH-1:0] rdata;
  logic [ELEM_WIDTH-1:0] elem_in;

  // read stage: word whose memory access is in flight
  logic      p1_valid_r, p1_valid_nxt;
  res_info_t p1_info_r;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_value_r;
  logic [4:0]    out_count_r;
  status_t       out_status_r;
  logic          out_load;
  logic [31:0]   res_value;

  // read stage may advance when the output register is free or draining
  assign out_load  = p1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p1_valid_r || !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // element data is cut to the element width on the way in
  assign elem_in = ELEM_WIDTH'(in_tdata[35:4]);

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .op       (op_t'(in_tuser)),
    .position (in_tdata[3:0]),
    .elem_in  (elem_in),
    .cmd      (cmd),
    .info     (info)
  );

  // read data register only moves on accept, so a stalled word keeps it
  cdq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (ELEM_WIDTH)
  ) u_ram (
    .clk   (clk),
    .en    (accept),
    .we    (cmd.we),
    .addr  (cmd.addr),
    .wdata (cmd.wdata),
    .rdata (rdata)
  );

  assign res_value = p1_info_r.from_mem ? 32'(rdata) : 32'(p1_info_r.imm);

  always_comb begin
    p1_valid_nxt = p1_valid_r;
    if (accept) begin
      p1_valid_nxt = 1'b1;
    end else if (out_load) begin
      p1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_info_r <= info;
    end
    if (out_load) begin
      out_value_r  <= res_value;
      out_count_r  <= 5'(p1_info_r.count);
      out_status_r <= p1_info_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_value_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  // a word in the read stage must not be overwritten or dropped while stalled
  a_p1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && out_valid_r && !out_tready |=> p1_valid_r && $stable(p1_info_r))
    else $error("read stage lost a word under stall");

  // back-pressure only when both stages are occupied
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> p1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  // count never exceeds the ring depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r |-> p1_info_r.count <= CNT_W'(DEPTH))
    else $error("element count past depth");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_value_r == '0)
    else $error("error result with nonzero value");

  // an out-of-range or empty status never comes from a memory read
  a_err_src: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && p1_info_r.status != ST_OK |-> !p1_info_r.from_mem)
    else $error("error word marked as memory read");
`endif

endmodule

[tb/circular_deque_test.sv]
// Self-checking testbench for the circular deque: directed table, then random traffic.
module circular_deque_test;
  import cdq_pkg::*;

  // codes outside the operation set; the block must answer them without a state change
  localparam logic [2:0] OP_UNUSED6 = 3'd6;
  localparam logic [2:0] OP_UNUSED7 = 3'd7;

  localparam int PLAN_ROWS   = 18;
  localparam int RANDOM_WORDS = 750;

  typedef struct packed {
    logic [31:0]      value;
    status_t          status;
    logic [CNT_W-1:0] count;
  } deque_result_t;

  // one row of the directed table; typed rows carry their own expected word
  typedef struct packed {
    logic [2:0]       op;
    logic [3:0]       pos;
    logic [31:0]      val;
    int               reps;
    bit               typed;
    logic [31:0]      exp_value;
    status_t          exp_status;
    logic [CNT_W-1:0] exp_count;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [3:0] position, [35:4] item_value, pad
  logic [IN_TUSER_W-1:0]  in_tuser;   // [2:0] operation
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [31:0] result_value, [36:32] count_now, pad
  logic [OUT_TUSER_W-1:0] out_tuser;  // [1:0] status

  // shadow deque
  logic [ELEM_WIDTH-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]      head_ptr   = '0;
  logic [CNT_W-1:0]      elem_count = '0;

  deque_result_t pending_results [$];
  int            mismatches = 0;
  bit            quiet      = 1'b0;  // no idling on either side while set

  stim_row_t plan [PLAN_ROWS] = '{
    '{OP_REMHI,   4'd0,  32'h0,         1,  1'b1, 32'h0,         ST_EMPTY, 5'd0},
    '{OP_REMLO,   4'd0,  32'h0,         1,  1'b1, 32'h0,         ST_EMPTY, 5'd0},
    '{OP_GET,     4'd0,  32'h0,         1,  1'b1, 32'h0,         ST_RANGE, 5'd0},
    '{OP_PUT,     4'd15, 32'hFFFF_FFFF, 1,  1'b1, 32'h0,         ST_RANGE, 5'd0},
    '{OP_UNUSED6, 4'd0,  32'h0,         1,  1'b1, 32'h0,         ST_OK,    5'd0},
    '{OP_ADDHI,   4'd0,  32'hFFFF_FFFF, 1,  1'b1, 32'hFFFF_FFFF, ST_OK,    5'd1},
    // head wraps below slot zero
    '{OP_ADDLO,   4'd0,  32'h0,         1,  1'b1, 32'h0,         ST_OK,    5'd2},
    '{OP_GET,     4'd0,  32'h0,         1,  1'b0, 32'h0,         ST_OK,    5'd0},
    '{OP_GET,     4'd2,  32'h0,         1,  1'b1, 32'h0,         ST_RANGE, 5'd2},
    '{OP_PUT,     4'd1,  32'hA5A5_A5A5, 1,  1'b0, 32'h0,         ST_OK,    5'd0},
    '{OP_UNUSED7, 4'd15, 32'hFFFF_FFFF, 1,  1'b1, 32'h0,         ST_OK,    5'd2},
    '{OP_ADDLO,   4'd0,  32'h1000_0000, 7,  1'b0, 32'h0,         ST_OK,    5'd0},
    '{OP_ADDHI,   4'd0,  32'h2000_0000, 7,  1'b0, 32'h0,         ST_OK,    5'd0},
    // now full
    '{OP_ADDHI,   4'd0,  32'h1234_5678, 1,  1'b1, 32'h0,         ST_FULL,  5'd16},
    '{OP_ADDLO,   4'd0,  32'h8765_4321, 1,  1'b1, 32'h0,         ST_FULL,  5'd16},
    '{OP_GET,     4'd15, 32'h0,         1,  1'b0, 32'h0,         ST_OK,    5'd0},
    '{OP_PUT,     4'd15, 32'h0,         1,  1'b0, 32'h0,         ST_OK,    5'd0},
    '{OP_REMLO,   4'd0,  32'h0,         1,  1'b0, 32'h0,         ST_OK,    5'd0}
  };

  circular_deque dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // applies one operation to the shadow deque and returns the word it should produce
  function automatic deque_result_t deque_apply(input logic [2:0] op, input logic [3:0] pos,
                                                input logic [31:0] val);
    deque_result_t r;
    int slot;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_GET, OP_PUT: begin
        if (pos >= elem_count) begin
          r.status = ST_RANGE;
        end else begin
          slot    = (int'(head_ptr) + int'(pos)) % DEPTH;
          r.value = 32'(ring_mem[slot]);
          if (op == OP_PUT) ring_mem[slot] = ELEM_WIDTH'(val);
        end
      end
      OP_ADDHI: begin
        if (elem_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot           = (int'(head_ptr) + int'(elem_count)) % DEPTH;
          ring_mem[slot] = ELEM_WIDTH'(val);
          elem_count     = elem_count + 1'b1;
          r.value        = 32'(ELEM_WIDTH'(val));
        end
      end
      OP_ADDLO: begin
        if (elem_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_ptr           = (head_ptr == 0) ? PTR_W'(DEPTH - 1) : head_ptr - 1'b1;
          ring_mem[head_ptr] = ELEM_WIDTH'(val);
          elem_count         = elem_count + 1'b1;
          r.value            = 32'(ELEM_WIDTH'(val));
        end
      end
      OP_REMHI: begin
        if (elem_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          elem_count = elem_count - 1'b1;
          slot       = (int'(head_ptr) + int'(elem_count)) % DEPTH;
          r.value    = 32'(ring_mem[slot]);
        end
      end
      OP_REMLO: begin
        if (elem_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value    = 32'(ring_mem[head_ptr]);
          head_ptr   = PTR_W'((int'(head_ptr) + 1) % DEPTH);
          elem_count = elem_count - 1'b1;
        end
      end
      default: ;
    endcase
    r.count = elem_count;
    return r;
  endfunction

  // drives one word, waits for the handshake, then queues what it should return
  task automatic send_word(input logic [2:0] op, input logic [3:0] pos, input logic [31:0] val,
                           input bit typed, input deque_result_t typed_res);
    deque_result_t r;
    @(negedge clk);
    if (!quiet) begin
      while ($urandom_range(99) < 11) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {{(IN_TDATA_W - 36){1'b0}}, val, pos};
    do @(posedge clk); while (!in_tready);
    r = deque_apply(op, pos, val);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // sender goes idle first so the last word is not offered again
  task automatic wait_drained;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // receiver back-pressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = quiet ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  // result checker: outputs are taken as they stood before the edge
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: tdata %h tuser %h", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          mismatches++;
        end
        if (out_tdata[36:32] !== want.count) begin
          $error("count_now: expected %0d, got %0d", want.count, out_tdata[36:32]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    deque_result_t typed_res;
    logic [2:0]    op;
    logic [3:0]    pos;
    logic [31:0]   val;
    int            add_pct;
    int            pick;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int k = 0; k < PLAN_ROWS; k++) begin
      typed_res = '{plan[k].exp_value, plan[k].exp_status, plan[k].exp_count};
      for (int j = 0; j < plan[k].reps; j++) begin
        send_word(plan[k].op, plan[k].pos, plan[k].val + 32'(j), plan[k].typed, typed_res);
      end
    end

    // random traffic; fill bias is drawn anew every 40 words so the deque swings full and empty
    add_pct = 50;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      quiet = (i >= 300 && i < 420);
      if (i == 500) wait_drained();
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       add_pct = 80;
          1:       add_pct = 20;
          default: add_pct = 50;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 2) begin
        op = ($urandom_range(1) != 0) ? OP_UNUSED7 : OP_UNUSED6;
      end else if (pick < 22) begin
        op = OP_GET;
      end else if (pick < 34) begin
        op = OP_PUT;
      end else if ($urandom_range(99) < add_pct) begin
        op = ($urandom_range(1) != 0) ? OP_ADDHI : OP_ADDLO;
      end else begin
        op = ($urandom_range(1) != 0) ? OP_REMHI : OP_REMLO;
      end
      // mostly legal indexes, some anywhere in the field
      if (elem_count != 0 && $urandom_range(3) != 0)
        pos = 4'($urandom_range(int'(elem_count) - 1));
      else
        pos = 4'($urandom_range(15));
      case ($urandom_range(19))
        0:       val = 32'h0;
        1:       val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      send_word(op, pos, val, 1'b0, '0);
    end
    quiet = 1'b0;
    @(negedge clk);
    in_tvalid = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
